// ----- rtl/core/at_response_stream_parser_defines.svh -----
// Assertion macros shared by the AT response stream parser RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef AT_RESPONSE_STREAM_PARSER_DEFINES_SVH
`define AT_RESPONSE_STREAM_PARSER_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define ATRSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the same cycle whenever the trigger is true.
`define ATRSP_ASSERT_IMPL(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define ATRSP_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/atrsp_pkg.sv -----
// Shared types, character codes and fixed keyword tables for the AT response parser.
// Used by atrsp_word_match and at_response_stream_parser; depends on nothing.
package atrsp_pkg;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;

  // Event codes reported on each result.
  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_OK          = 4'd1,
    EV_ERROR       = 4'd2,
    EV_SEND_OK     = 4'd3,
    EV_SEND_FAIL   = 4'd4,
    EV_READY       = 4'd5,
    EV_WIFI_CONN   = 4'd6,
    EV_WIFI_DISC   = 4'd7,
    EV_GOT_IP      = 4'd8,
    EV_CONN_OPEN   = 4'd9,
    EV_CONN_CLOSED = 4'd10,
    EV_PAYLOAD     = 4'd11,
    EV_PARSE_ERR   = 4'd12,
    EV_INVALID     = 4'd13
  } event_t;

  // Keywords tracked by the word matcher.
  localparam int N_WORDS      = 11;
  localparam int W_IPD        = 0;
  localparam int W_OK         = 1;
  localparam int W_ERROR      = 2;
  localparam int W_SEND_OK    = 3;
  localparam int W_SEND_FAIL  = 4;
  localparam int W_READY      = 5;
  localparam int W_WIFI_CONN  = 6;
  localparam int W_WIFI_DISC  = 7;
  localparam int W_GOT_IP     = 8;
  localparam int W_CONNECT    = 9;
  localparam int W_CLOSED     = 10;

  // Longest keyword, in characters.
  localparam int WORD_TEXT_LEN = 15;

  // Word buffer operations.
  typedef enum logic [1:0] {
    WOP_HOLD,   // leave the word unchanged
    WOP_CLEAR,  // empty the word
    WOP_START,  // empty the word, then append the character
    WOP_PUT     // append the character if there is room
  } word_op_t;

  // Control from the parser to the word matcher.
  typedef struct packed {
    word_op_t   op;
    logic [7:0] ch;
  } word_ctl_t;

  // Status from the word matcher: exact keyword hits for the word as it is
  // and for the word with the current character appended.
  typedef struct packed {
    logic [N_WORDS-1:0] cur_exact;
    logic [N_WORDS-1:0] put_exact;
    logic               echo;        // two or more characters, starting with "AT"
    logic               full;        // word holds its full capacity
    logic               conn_limit;  // nine or more characters after appending
  } word_stat_t;

  // Keyword text, left aligned and padded with zero bytes.
  function automatic logic [8*WORD_TEXT_LEN-1:0] word_text(input logic [3:0] k);
    logic [8*WORD_TEXT_LEN-1:0] t;
    t = '0;
    unique case (k)
      4'(W_IPD):       t = {"+IPD",            {11{8'h00}}};
      4'(W_OK):        t = {"OK",              {13{8'h00}}};
      4'(W_ERROR):     t = {"ERROR",           {10{8'h00}}};
      4'(W_SEND_OK):   t = {"SEND OK",         {8{8'h00}}};
      4'(W_SEND_FAIL): t = {"SEND FAIL",       {6{8'h00}}};
      4'(W_READY):     t = {"ready",           {10{8'h00}}};
      4'(W_WIFI_CONN): t = {"WIFI CONNECTED",  {1{8'h00}}};
      4'(W_WIFI_DISC): t = "WIFI DISCONNECT";
      4'(W_GOT_IP):    t = {"WIFI GOT IP",     {4{8'h00}}};
      4'(W_CONNECT):   t = {"CONNECT",         {8{8'h00}}};
      4'(W_CLOSED):    t = {"CLOSED",          {9{8'h00}}};
      default:         t = '0;
    endcase
    return t;
  endfunction

  // Keyword length in characters.
  function automatic logic [3:0] word_len(input logic [3:0] k);
    logic [3:0] n;
    n = '0;
    unique case (k)
      4'(W_IPD):       n = 4'd4;
      4'(W_OK):        n = 4'd2;
      4'(W_ERROR):     n = 4'd5;
      4'(W_SEND_OK):   n = 4'd7;
      4'(W_SEND_FAIL): n = 4'd9;
      4'(W_READY):     n = 4'd5;
      4'(W_WIFI_CONN): n = 4'd14;
      4'(W_WIFI_DISC): n = 4'd15;
      4'(W_GOT_IP):    n = 4'd11;
      4'(W_CONNECT):   n = 4'd7;
      4'(W_CLOSED):    n = 4'd6;
      default:         n = 4'd0;
    endcase
    return n;
  endfunction

  // Character at position p of keyword k; p must be below 15.
  function automatic logic [7:0] word_char(input logic [3:0] k, input logic [3:0] p);
    logic [8*WORD_TEXT_LEN-1:0] t;
    logic [3:0]                 q;
    t = word_text(k);
    q = 4'd14 - p;
    return t[{q, 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/core/atrsp_word_match.sv -----
// Incremental keyword matcher for the AT response parser: keeps the word length
// and one running prefix-match bit per keyword instead of the characters. Uses atrsp_pkg.
module atrsp_word_match #(
  parameter int WORD_CAPACITY = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  atrsp_pkg::word_ctl_t   ctl,
  output atrsp_pkg::word_stat_t  stat
);

  localparam int CW = $clog2(WORD_CAPACITY + 1);

  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic [atrsp_pkg::N_WORDS-1:0]  match;
  logic [atrsp_pkg::N_WORDS-1:0]  match_next;
  logic                           at_pref;
  logic                           at_pref_next;

  // Prefix bits and length for the word with ctl.ch appended at position pos.
  logic [CW-1:0]                  pos;
  logic [CW-1:0]                  put_count;
  logic [atrsp_pkg::N_WORDS-1:0]  put_match;
  logic                           put_at;
  logic                           room;

  // Append logic: a keyword stays a candidate while every character so far matches.
  always_comb begin
    pos  = (ctl.op == atrsp_pkg::WOP_START) ? '0 : count;
    room = (ctl.op == atrsp_pkg::WOP_START) || (count < CW'(WORD_CAPACITY));
    put_count = room ? CW'(pos + 1'b1) : count;
    for (int k = 0; k < atrsp_pkg::N_WORDS; k++) begin
      put_match[k] = room
                   ? (((pos == '0) || match[k])
                      && (pos < {{(CW-4){1'b0}}, atrsp_pkg::word_len(4'(k))})
                      && (ctl.ch == atrsp_pkg::word_char(4'(k), pos[3:0])))
                   : match[k];
    end
    if (!room) begin
      put_at = at_pref;
    end else if (pos == '0) begin
      put_at = (ctl.ch == atrsp_pkg::CH_A);
    end else if (pos == CW'(1)) begin
      put_at = at_pref && (ctl.ch == atrsp_pkg::CH_T);
    end else begin
      put_at = at_pref;
    end
  end

  // Next register values per operation.
  always_comb begin
    count_next   = count;
    match_next   = match;
    at_pref_next = at_pref;
    unique case (ctl.op)
      atrsp_pkg::WOP_HOLD: begin
      end
      atrsp_pkg::WOP_CLEAR: begin
        count_next = '0;
      end
      atrsp_pkg::WOP_START, atrsp_pkg::WOP_PUT: begin
        count_next   = put_count;
        match_next   = put_match;
        at_pref_next = put_at;
      end
      default: begin
      end
    endcase
  end

  // Word length and match bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    match   <= match_next;
    at_pref <= at_pref_next;
  end

  // Status: exact hits need the full keyword length as well.
  always_comb begin
    for (int k = 0; k < atrsp_pkg::N_WORDS; k++) begin
      stat.cur_exact[k] = match[k]
                        && (count == {{(CW-4){1'b0}}, atrsp_pkg::word_len(4'(k))});
      stat.put_exact[k] = put_match[k]
                        && (put_count == {{(CW-4){1'b0}}, atrsp_pkg::word_len(4'(k))});
    end
    stat.echo       = at_pref && (count >= CW'(2));
    stat.full       = (count >= CW'(WORD_CAPACITY));
    stat.conn_limit = (put_count >= CW'(9));
  end

endmodule

// ----- rtl/core/at_response_stream_parser.sv -----
// Top level of the AT response stream parser: input register, parse step, result register.
// Depends on atrsp_pkg, atrsp_word_match and at_response_stream_parser_defines.svh.
//
//   Channel  Handshake            Content
//   s_       s_tvalid/s_tready    s_tdata: received character
//   m_       m_tvalid/m_tready    m_tdata: result fields, m_tuser: event, m_tlast: last payload byte
//   cfg_     cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// Each character gives exactly one result. It is parsed from the input register into the result
// register, which raises m_tvalid. One character per cycle is sustained while m_tready stays
// high; the parse step sits between the input register and the result register.
// A stall on m_ backs up through the input register into s_tready.
// Synchronous reset returns to idle with the limits at 5 and 2048; no clearing pass.
// cfg_ready is always high; writes to indexes other than 0 and 1 are ignored.
`include "at_response_stream_parser_defines.svh"

module at_response_stream_parser #(
  parameter int WORD_CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [6:0] conn_number, [22:7] frame_length,
                                  // [30:23] payload_byte, [31] prompt_seen,
                                  // [32] may_send, [36:33] parser_state, [39:37] zero
  output logic [3:0]  m_tuser,    // [3:0] event_res
  output logic        m_tlast,    // last_byte
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // Register indexes.
  localparam logic [1:0] REG_ID_LIMIT  = 2'd0;
  localparam logic [1:0] REG_LEN_LIMIT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_WORD      = 4'd1,
    ST_ID        = 4'd2,
    ST_CONN_WORD = 4'd3,
    ST_IPD_ID    = 4'd4,
    ST_LEN       = 4'd5,
    ST_DATA      = 4'd6,
    ST_SKIP      = 4'd7,
    ST_ECHO      = 4'd8
  } pstate_t;

  // Configuration.
  logic [3:0]  id_limit;
  logic [11:0] length_limit;

  // Input register.
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;

  // Parser state.
  pstate_t     state, state_next;
  logic [6:0]  id_value, id_value_next;
  logic [15:0] length_value, length_value_next;
  logic [11:0] payload_count, payload_count_next;
  logic        was_idle;

  // Result register.
  logic [3:0]  r_event;
  logic [6:0]  r_conn;
  logic [15:0] r_flen;
  logic [7:0]  r_pbyte;
  logic        r_last;
  logic        r_prompt;
  logic        r_may_send;
  logic [3:0]  r_state;

  // Parse step outputs.
  atrsp_pkg::event_t ev;
  logic [6:0]  num;
  logic [15:0] flen;
  logic [7:0]  pbyte;
  logic        last;
  logic        prompt;
  atrsp_pkg::word_op_t wop;

  atrsp_pkg::word_ctl_t  wctl;
  atrsp_pkg::word_stat_t wstat;

  // Character classes and arithmetic.
  logic        c_nl, c_blank, c_num, c_letter;
  logic [3:0]  dig;
  logic [19:0] len_mul;
  logic [15:0] len_new;
  logic [10:0] id_mul;
  logic [6:0]  id_new;
  logic [11:0] pc_new;
  logic        num_ok;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit     <= 4'd5;
      length_limit <= 12'd2048;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ID_LIMIT) begin
        id_limit <= cfg_data[3:0];
      end else if (cfg_index == REG_LEN_LIMIT) begin
        length_limit <= cfg_data;
      end
    end
  end

  // Input register: refills in the cycle its character moves on.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Keyword matcher.
  assign wctl.op = advance ? wop : atrsp_pkg::WOP_HOLD;
  assign wctl.ch = in_byte;

  atrsp_word_match #(
    .WORD_CAPACITY(WORD_CAPACITY)
  ) u_word_match (
    .clk  (clk),
    .rst  (rst),
    .ctl  (wctl),
    .stat (wstat)
  );

  // Event for a finished status line.
  function automatic atrsp_pkg::event_t line_event(input logic [atrsp_pkg::N_WORDS-1:0] hit);
    atrsp_pkg::event_t e;
    priority if (hit[atrsp_pkg::W_OK])        e = atrsp_pkg::EV_OK;
    else if (hit[atrsp_pkg::W_ERROR])         e = atrsp_pkg::EV_ERROR;
    else if (hit[atrsp_pkg::W_SEND_OK])       e = atrsp_pkg::EV_SEND_OK;
    else if (hit[atrsp_pkg::W_SEND_FAIL])     e = atrsp_pkg::EV_SEND_FAIL;
    else if (hit[atrsp_pkg::W_READY])         e = atrsp_pkg::EV_READY;
    else if (hit[atrsp_pkg::W_WIFI_CONN])     e = atrsp_pkg::EV_WIFI_CONN;
    else if (hit[atrsp_pkg::W_WIFI_DISC])     e = atrsp_pkg::EV_WIFI_DISC;
    else if (hit[atrsp_pkg::W_GOT_IP])        e = atrsp_pkg::EV_GOT_IP;
    else                                      e = atrsp_pkg::EV_PARSE_ERR;
    return e;
  endfunction

  // Character classes, the times-ten step for ids and lengths, and the payload count.
  always_comb begin
    c_nl     = (in_byte == atrsp_pkg::CH_CR) || (in_byte == atrsp_pkg::CH_LF);
    c_blank  = (in_byte == atrsp_pkg::CH_SPACE) || (in_byte == atrsp_pkg::CH_TAB);
    c_num    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    c_letter = ((in_byte >= 8'h61) && (in_byte <= 8'h7A))
            || ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
    dig      = in_byte[3:0];
    len_mul  = {1'b0, length_value, 3'b000} + {3'b000, length_value, 1'b0} + {16'd0, dig};
    len_new  = len_mul[15:0];
    id_mul   = {1'b0, id_value, 3'b000} + {3'b000, id_value, 1'b0} + {7'd0, dig};
    id_new   = (id_mul > 11'd127) ? 7'd127 : id_mul[6:0];
    pc_new   = payload_count + 12'd1;
    num_ok   = (state == ST_LEN) ? (len_new <= {4'd0, length_limit})
                                 : (id_new < {3'd0, id_limit});
  end

  // Parse step for one character.
  always_comb begin
    ev                 = atrsp_pkg::EV_NONE;
    num                = '0;
    flen               = '0;
    pbyte              = '0;
    last               = 1'b0;
    prompt             = 1'b0;
    wop                = atrsp_pkg::WOP_HOLD;
    state_next         = state;
    id_value_next      = id_value;
    length_value_next  = length_value;
    payload_count_next = payload_count;

    unique case (state)
      ST_IDLE: begin
        priority if (c_nl || c_blank) begin
        end else if (in_byte == atrsp_pkg::CH_GT) begin
          prompt = 1'b1;
        end else if (c_num) begin
          id_value_next      = {3'd0, dig};
          length_value_next  = '0;
          payload_count_next = '0;
          wop                = atrsp_pkg::WOP_CLEAR;
          if (dig < id_limit) begin
            state_next = ST_ID;
          end else begin
            ev         = atrsp_pkg::EV_INVALID;
            num        = {3'd0, dig};
            state_next = ST_SKIP;
          end
        end else if (c_letter || (in_byte == atrsp_pkg::CH_PLUS)) begin
          wop        = atrsp_pkg::WOP_START;
          state_next = ST_WORD;
        end else begin
          state_next = ST_SKIP;
        end
      end

      ST_WORD: begin
        priority if (in_byte == atrsp_pkg::CH_COMMA) begin
          if (wstat.cur_exact[atrsp_pkg::W_IPD]) begin
            wop                = atrsp_pkg::WOP_CLEAR;
            length_value_next  = '0;
            payload_count_next = '0;
            id_value_next      = '0;
            state_next         = ST_IPD_ID;
          end else begin
            ev         = atrsp_pkg::EV_PARSE_ERR;
            state_next = ST_SKIP;
          end
        end else if (c_letter || c_blank) begin
          if (wstat.full) begin
            ev         = atrsp_pkg::EV_PARSE_ERR;
            state_next = ST_SKIP;
          end else begin
            wop = atrsp_pkg::WOP_PUT;
          end
        end else if (c_nl) begin
          if (wstat.echo) begin
            state_next = ST_ECHO;
          end else begin
            ev         = line_event(wstat.cur_exact);
            state_next = ST_IDLE;
          end
        end else begin
          ev         = atrsp_pkg::EV_PARSE_ERR;
          state_next = ST_SKIP;
        end
      end

      ST_ID, ST_IPD_ID, ST_LEN: begin
        priority if (c_num) begin
          if (state == ST_LEN) begin
            length_value_next = len_new;
          end else begin
            id_value_next = id_new;
          end
          if (!num_ok) begin
            ev         = atrsp_pkg::EV_INVALID;
            num        = (state == ST_LEN) ? id_value : id_new;
            flen       = (state == ST_LEN) ? len_new : length_value;
            state_next = ST_SKIP;
          end
        end else if ((state == ST_LEN) && (in_byte == atrsp_pkg::CH_COLON)) begin
          state_next = (length_value == '0) ? ST_IDLE : ST_DATA;
        end else if ((state != ST_LEN) && (in_byte == atrsp_pkg::CH_COMMA)) begin
          state_next = (state == ST_IPD_ID) ? ST_LEN : ST_CONN_WORD;
        end else begin
          ev         = atrsp_pkg::EV_INVALID;
          num        = id_value;
          state_next = c_nl ? ST_IDLE : ST_SKIP;
        end
      end

      ST_CONN_WORD: begin
        if (c_letter) begin
          wop = atrsp_pkg::WOP_PUT;
          priority if (wstat.put_exact[atrsp_pkg::W_CONNECT]) begin
            ev         = atrsp_pkg::EV_CONN_OPEN;
            num        = id_value;
            state_next = ST_IDLE;
          end else if (wstat.put_exact[atrsp_pkg::W_CLOSED]) begin
            ev         = atrsp_pkg::EV_CONN_CLOSED;
            num        = id_value;
            state_next = ST_IDLE;
          end else if (wstat.conn_limit) begin
            ev         = atrsp_pkg::EV_PARSE_ERR;
            state_next = ST_SKIP;
          end else begin
          end
        end else begin
          ev         = atrsp_pkg::EV_PARSE_ERR;
          state_next = c_nl ? ST_IDLE : ST_SKIP;
        end
      end

      ST_DATA: begin
        payload_count_next = pc_new;
        ev                 = atrsp_pkg::EV_PAYLOAD;
        num                = id_value;
        pbyte              = in_byte;
        if ({4'd0, pc_new} == length_value) begin
          last       = 1'b1;
          flen       = length_value;
          state_next = ST_IDLE;
        end
      end

      // Skip and echo both wait for whitespace or a newline.
      default: begin
        if (c_nl || c_blank) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Parser state and result register, both updated as a character moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      id_value      <= '0;
      length_value  <= '0;
      payload_count <= '0;
      was_idle      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) begin
        state         <= state_next;
        id_value      <= id_value_next;
        length_value  <= length_value_next;
        payload_count <= payload_count_next;
        was_idle      <= (state_next == ST_IDLE);
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      r_event    <= ev;
      r_conn     <= num;
      r_flen     <= flen;
      r_pbyte    <= pbyte;
      r_last     <= last;
      r_prompt   <= prompt;
      r_may_send <= !was_idle && (state_next == ST_IDLE);
      r_state    <= state_next;
    end
  end

  // Result transaction fields.
  assign m_tdata = {3'b000, r_state, r_may_send, r_prompt, r_pbyte, r_flen, r_conn};
  assign m_tuser = r_event;
  assign m_tlast = r_last;

  // Checks on the parse logic.
  `ATRSP_ASSERT_IMPL(a_last_is_payload, m_tvalid && m_tlast, m_tuser == atrsp_pkg::EV_PAYLOAD, "last byte flag on a non-payload event")
  `ATRSP_ASSERT_IMPL(a_may_send_idle, m_tvalid && m_tdata[32], m_tdata[36:33] == ST_IDLE, "may_send raised outside idle")
  `ATRSP_ASSERT(a_data_count, (state != ST_DATA) || ({4'd0, payload_count} < length_value), "payload count ran past the frame length")
  `ATRSP_ASSERT_NEXT(a_result_loaded, advance, m_tvalid, "parsed character produced no result")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for at_response_stream_parser: modem text goes in one character per
// transaction, and each result transaction is checked against an in-bench parser model.
// Depends on atrsp_pkg and the at_response_stream_parser RTL.

module tb_top;

  localparam int WORD_CAP      = 32;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;

  // Register indexes on the write channel; the last two are not implemented.
  localparam logic [1:0] REG_ID_LIMIT     = 2'd0;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd1;
  localparam logic [1:0] REG_SPARE_LOW    = 2'd2;
  localparam logic [1:0] REG_SPARE_HIGH   = 2'd3;

  typedef enum logic [3:0] {
    PS_IDLE, PS_WORD, PS_ID, PS_CONN_WORD, PS_IPD_ID, PS_LEN, PS_DATA, PS_SKIP, PS_ECHO
  } parse_state_t;

  typedef struct packed {
    atrsp_pkg::event_t ev;
    logic [6:0]  conn;
    logic [15:0] flen;
    logic [7:0]  data;
    logic        last;
    logic        prompt;
    logic        may_send;
    logic [3:0]  state;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // Parser model state and its copy of the limits.
  parse_state_t cur_state  = PS_IDLE;
  logic [7:0]   word_buf [WORD_CAP];
  int unsigned  word_fill  = 0;
  int unsigned  conn_id    = 0;
  int unsigned  frame_len  = 0;
  int unsigned  bytes_seen = 0;
  logic         was_idle_q = 1'b0;
  int unsigned  id_cap     = 5;
  int unsigned  len_cap    = 2048;

  parse_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   bytes_sent  = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  bit            calm = 1'b0;
  bit            sender_gaps = 1'b1;
  bit            stalls_on = 1'b1;

  string status_words [8] = '{"OK", "ERROR", "SEND OK", "SEND FAIL", "ready",
                              "WIFI CONNECTED", "WIFI DISCONNECT", "WIFI GOT IP"};

  at_response_stream_parser #(.WORD_CAPACITY(WORD_CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Character classes.
  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_eol(input logic [7:0] c);
    return c == atrsp_pkg::CH_CR || c == atrsp_pkg::CH_LF;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == atrsp_pkg::CH_SPACE || c == atrsp_pkg::CH_TAB;
  endfunction

  function automatic bit word_matches(input string s);
    if (word_fill != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (word_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void append_char(input logic [7:0] c);
    if (word_fill < WORD_CAP) begin
      word_buf[word_fill] = c;
      word_fill++;
    end
  endfunction

  function automatic atrsp_pkg::event_t status_event();
    if (word_matches("OK")) return atrsp_pkg::EV_OK;
    if (word_matches("ERROR")) return atrsp_pkg::EV_ERROR;
    if (word_matches("SEND OK")) return atrsp_pkg::EV_SEND_OK;
    if (word_matches("SEND FAIL")) return atrsp_pkg::EV_SEND_FAIL;
    if (word_matches("ready")) return atrsp_pkg::EV_READY;
    if (word_matches("WIFI CONNECTED")) return atrsp_pkg::EV_WIFI_CONN;
    if (word_matches("WIFI DISCONNECT")) return atrsp_pkg::EV_WIFI_DISC;
    if (word_matches("WIFI GOT IP")) return atrsp_pkg::EV_GOT_IP;
    return atrsp_pkg::EV_PARSE_ERR;
  endfunction

  // Advances the parser model by one character and returns the result it gives.
  function automatic parse_result_t parse_char(input logic [7:0] c);
    parse_result_t r;
    parse_state_t  nxt;
    int unsigned   v;
    bit            ok;
    r = '0;
    nxt = cur_state;
    case (cur_state)
      PS_IDLE: begin
        if (c == atrsp_pkg::CH_GT) begin
          r.prompt = 1'b1;
        end else if (is_digit(c)) begin
          conn_id = c - "0";
          frame_len = 0;
          bytes_seen = 0;
          word_fill = 0;
          if (conn_id < id_cap) begin
            nxt = PS_ID;
          end else begin
            r.ev = atrsp_pkg::EV_INVALID;
            r.conn = 7'(conn_id);
            nxt = PS_SKIP;
          end
        end else if (is_letter(c) || c == atrsp_pkg::CH_PLUS) begin
          word_fill = 0;
          append_char(c);
          nxt = PS_WORD;
        end else if (!is_eol(c) && !is_blank(c)) begin
          nxt = PS_SKIP;
        end
      end
      PS_WORD: begin
        if (c == atrsp_pkg::CH_COMMA) begin
          if (word_matches("+IPD")) begin
            word_fill = 0;
            frame_len = 0;
            bytes_seen = 0;
            conn_id = 0;
            nxt = PS_IPD_ID;
          end else begin
            r.ev = atrsp_pkg::EV_PARSE_ERR;
            nxt = PS_SKIP;
          end
        end else if (is_letter(c) || is_blank(c)) begin
          if (word_fill >= WORD_CAP) begin
            r.ev = atrsp_pkg::EV_PARSE_ERR;
            nxt = PS_SKIP;
          end else begin
            append_char(c);
          end
        end else if (is_eol(c)) begin
          // A line that starts with AT is the command echo.
          if (word_fill >= 2 && word_buf[0] == atrsp_pkg::CH_A
              && word_buf[1] == atrsp_pkg::CH_T) begin
            nxt = PS_ECHO;
          end else begin
            r.ev = status_event();
            nxt = PS_IDLE;
          end
        end else begin
          r.ev = atrsp_pkg::EV_PARSE_ERR;
          nxt = PS_SKIP;
        end
      end
      PS_ID, PS_IPD_ID, PS_LEN: begin
        if (is_digit(c)) begin
          if (cur_state == PS_LEN) begin
            frame_len = (frame_len * 10 + (c - "0")) & 32'hFFFF;
            ok = frame_len <= len_cap;
          end else begin
            v = conn_id * 10 + (c - "0");
            conn_id = (v > 127) ? 127 : v;
            ok = conn_id < id_cap;
          end
          if (!ok) begin
            r.ev = atrsp_pkg::EV_INVALID;
            r.conn = 7'(conn_id);
            r.flen = 16'(frame_len);
            nxt = PS_SKIP;
          end
        end else if ((cur_state == PS_LEN) ? (c == atrsp_pkg::CH_COLON)
                                           : (c == atrsp_pkg::CH_COMMA)) begin
          if (cur_state == PS_LEN) nxt = (frame_len == 0) ? PS_IDLE : PS_DATA;
          else nxt = (cur_state == PS_IPD_ID) ? PS_LEN : PS_CONN_WORD;
        end else begin
          r.ev = atrsp_pkg::EV_INVALID;
          r.conn = 7'(conn_id);
          nxt = is_eol(c) ? PS_IDLE : PS_SKIP;
        end
      end
      PS_CONN_WORD: begin
        if (is_letter(c)) begin
          append_char(c);
          if (word_matches("CONNECT")) begin
            r.ev = atrsp_pkg::EV_CONN_OPEN;
            r.conn = 7'(conn_id);
            nxt = PS_IDLE;
          end else if (word_matches("CLOSED")) begin
            r.ev = atrsp_pkg::EV_CONN_CLOSED;
            r.conn = 7'(conn_id);
            nxt = PS_IDLE;
          end else if (word_fill >= 9) begin
            r.ev = atrsp_pkg::EV_PARSE_ERR;
            nxt = PS_SKIP;
          end
        end else begin
          r.ev = atrsp_pkg::EV_PARSE_ERR;
          nxt = is_eol(c) ? PS_IDLE : PS_SKIP;
        end
      end
      PS_DATA: begin
        bytes_seen = (bytes_seen + 1) & 32'hFFF;
        r.ev = atrsp_pkg::EV_PAYLOAD;
        r.conn = 7'(conn_id);
        r.data = c;
        if (bytes_seen == frame_len) begin
          r.last = 1'b1;
          r.flen = 16'(frame_len);
          nxt = PS_IDLE;
        end
      end
      // Skip, echo and unused codes wait for whitespace or a newline.
      default: begin
        if (is_eol(c) || is_blank(c)) nxt = PS_IDLE;
      end
    endcase
    cur_state = nxt;
    r.state = nxt;
    r.may_send = !was_idle_q && nxt == PS_IDLE;
    was_idle_q = (nxt == PS_IDLE);
    return r;
  endfunction

  // Sends one character, with an occasional idle burst in front of it.
  task automatic send_byte(input logic [7:0] b);
    if (bytes_sent % 40 == 0) sender_gaps = !calm && ($urandom_range(0, 2) != 0);
    if (sender_gaps && !calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(parse_char(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 2))
      0: begin
        send_byte(atrsp_pkg::CH_CR);
        send_byte(atrsp_pkg::CH_LF);
      end
      1: send_byte(atrsp_pkg::CH_LF);
      default: send_byte(atrsp_pkg::CH_CR);
    endcase
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_eol();
  endtask

  // Holds the sender off until every pending result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ID_LIMIT:     id_cap = value[3:0];
      REG_LENGTH_LIMIT: len_cap = value;
      default: ;
    endcase
  endtask

  // The id limit is written with random upper bits, which the block must drop.
  task automatic set_limits(input int unsigned id_lim, input int unsigned len_lim);
    write_reg(REG_ID_LIMIT, {8'($urandom), 4'(id_lim)});
    write_reg(REG_LENGTH_LIMIT, 12'(len_lim));
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic string rand_letters(input int unsigned n);
    string s;
    s = "";
    repeat (n) s = $sformatf("%s%c", s, rand_letter());
    return s;
  endfunction

  function automatic int unsigned rand_id();
    return $urandom_range(0, id_cap - 1);
  endfunction

  function automatic int unsigned at_most(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // One random line: mostly well-formed responses with random content, some noise.
  task automatic send_random_line();
    string       line;
    string       word;
    int unsigned n;
    line = "";
    case ($urandom_range(0, 19))
      0, 1, 2, 3: line = status_words[$urandom_range(0, 7)];
      4, 5: begin
        line = "AT";
        repeat ($urandom_range(0, 6)) line = $sformatf("%s%c", line, rand_letter());
        send_line(line);
        line = rand_letters($urandom_range(0, 4));
      end
      6, 7, 8: begin
        case ($urandom_range(0, 5))
          0, 1: word = "CONNECT";
          2, 3: word = "CLOSED";
          4: word = "CLOSE";
          default: word = rand_letters($urandom_range(1, 10));
        endcase
        line = $sformatf("%0d,%s", rand_id(), word);
      end
      9, 10, 11, 12, 13: begin
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, at_most(len_cap, 64));
        else n = $urandom_range(0, at_most(len_cap, 12));
        send_text($sformatf("+IPD,%0d,%0d:", rand_id(), n));
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        return;
      end
      14: line = ">";
      15: begin
        if ($urandom_range(0, 1))
          line = $sformatf("+IPD,%0d,%0d:", rand_id(), len_cap + $urandom_range(1, 200));
        else
          line = $sformatf("%0d,CLOSED", id_cap + $urandom_range(0, 20));
      end
      16: begin
        // A well-formed header cut short and followed by a stray character.
        if ($urandom_range(0, 1))
          line = $sformatf("+IPD,%0d,%0d:", rand_id(), $urandom_range(1, 9));
        else
          line = $sformatf("%0d,CONNECT", rand_id());
        send_text(line.substr(0, $urandom_range(0, line.len() - 2)));
        word = ",: #9x>";
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        else send_byte(word[$urandom_range(0, word.len() - 1)]);
        line = "";
      end
      17: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      18: line = rand_letters($urandom_range(28, 36));
      default: begin
        line = status_words[$urandom_range(0, 7)];
        line[$urandom_range(0, line.len() - 1)] = rand_letter();
      end
    endcase
    send_line(line);
  endtask

  task automatic test_status_lines();
    foreach (status_words[i]) send_line(status_words[i]);
    send_line("A");
    send_line("WIFI GOT-IP");
    send_line("ready now");
    send_line({4{"xxxxxxxx"}});
    send_line({"y", {4{"xxxxxxxx"}}});
  endtask

  task automatic test_echo_and_prompt();
    send_byte(atrsp_pkg::CH_GT);
    send_line("AT");
    send_text("ATE GMR");
    send_byte(atrsp_pkg::CH_CR);
    send_text("xyz");
    send_byte(atrsp_pkg::CH_TAB);
    send_text("O>");
    send_byte(atrsp_pkg::CH_SPACE);
    send_text("#junk");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(atrsp_pkg::CH_SPACE);
  endtask

  task automatic test_connections();
    send_line("0,CONNECT");
    send_line("4,CLOSED");
    send_line("1,CONNEXION");
    send_line("2,FOO");
    send_line("2,CL1");
    send_line("3x");
    send_line("3");
    send_line("9");
    send_line("5,CONNECT");
  endtask

  task automatic test_receive_frames();
    send_text("+IPD,0,3:");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(atrsp_pkg::CH_LF);
    send_text("+IPD,1,0:");
    send_line("+IPD,7,1:");
    send_line("+IPD,1,9999:");
    send_line("+IPD,1,12x");
    send_line("+IPX,3");
    send_text("+IPD,4,2:");
    send_byte(atrsp_pkg::CH_CR);
    send_byte(atrsp_pkg::CH_LF);
  endtask

  // Limit extremes, including the id limit high enough for the stored id to saturate.
  task automatic test_number_limits();
    set_limits(15, 1);
    send_line("14,CONNECT");
    send_text("139 ");
    send_text("+IPD,2,1:Z");
    send_line("+IPD,2,2:");
    send_text("+IPD,0,01:Q");
    set_limits(1, 4095);
    send_line("0,CLOSED");
    send_line("1,CLOSED");
    send_line("+IPD,0,4096:");
    write_reg(REG_SPARE_LOW, 12'($urandom));
    write_reg(REG_SPARE_HIGH, 12'($urandom));
    send_line("0,CONNECT");
  endtask

  task automatic test_random_traffic();
    int unsigned id_limits [5];
    int unsigned len_limits [5];
    int unsigned target;
    id_limits = '{5, 1, 10, 15, 3};
    len_limits = '{2048, 1, 4095, 20, 300};
    foreach (id_limits[i]) begin
      set_limits(id_limits[i], len_limits[i]);
      target = bytes_sent + 150;
      while (bytes_sent < target) send_random_line();
    end
  endtask

  // A long frame under the largest length limit.
  task automatic test_long_frame();
    set_limits(10, 4095);
    send_text("+IPD,9,480:");
    repeat (480) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_quiet_tail();
    int unsigned target;
    set_limits(7, 100);
    calm = 1'b1;
    target = bytes_sent + 150;
    while (bytes_sent < target) send_random_line();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_status_lines();
    test_echo_and_prompt();
    test_connections();
    test_receive_frames();
    test_number_limits();
    test_random_traffic();
    test_long_frame();
    test_quiet_tail();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("at_response_stream_parser verification clean");
    else $display("at_response_stream_parser verification failed");
    $finish;
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  // Each result transaction is compared with the oldest pending prediction.
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, got event %0d", $time, m_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", want.ev, m_tuser);
        check_field("conn_number", want.conn, m_tdata[6:0]);
        check_field("frame_length", want.flen, m_tdata[22:7]);
        check_field("payload_byte", want.data, m_tdata[30:23]);
        check_field("prompt_seen", want.prompt, m_tdata[31]);
        check_field("may_send", want.may_send, m_tdata[32]);
        check_field("parser_state", want.state, m_tdata[36:33]);
        check_field("tdata padding", 0, m_tdata[39:37]);
        check_field("last_byte", want.last, m_tlast);
      end
    end
  end

  // Receiver back-pressure in bursts, switched on and off in stretches.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 150 == 0) stalls_on = $urandom_range(0, 2) != 0;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stalls_on && !calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Ends the run if no transaction completes on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("at_response_stream_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
